FILE: rtl/core/wncc_pkg.sv
// Shared constants, types and opcodes for the weighted nearest-color classifier.
package wncc_pkg;

    localparam int DEF_MAX_SEEDS = 16;
    localparam int DEF_CHANNELS  = 5;

    localparam int COLOR_W  = 8;
    localparam int CH_W     = 3;
    localparam int WEIGHT_W = 16;
    localparam int IDX_W    = 4;
    localparam int CNT_W    = 5;
    localparam int SQ_W     = 2 * COLOR_W;
    localparam int DIST_W   = SQ_W + 2;          // sum of three squares
    localparam int PROD_W   = DIST_W + WEIGHT_W;

    typedef enum logic
    {
        OP_LOAD     = 1'b0,
        OP_CLASSIFY = 1'b1
    } opcode_t;

    typedef struct packed
    {
        logic [COLOR_W-1:0]  tgt_r;
        logic [COLOR_W-1:0]  tgt_g;
        logic [COLOR_W-1:0]  tgt_b;
        logic [CH_W-1:0]     ch;
        logic [WEIGHT_W-1:0] weight;
        logic [COLOR_W-1:0]  paint_r;
        logic [COLOR_W-1:0]  paint_g;
        logic [COLOR_W-1:0]  paint_b;
    } seed_t;

endpackage

FILE: rtl/core/wncc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wncc_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/wncc_dist.sv
// Squared RGB distance unit, result registered.
module wncc_dist
    import wncc_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [COLOR_W-1:0] pix_r,
    input  logic [COLOR_W-1:0] pix_g,
    input  logic [COLOR_W-1:0] pix_b,
    input  logic [COLOR_W-1:0] tgt_r,
    input  logic [COLOR_W-1:0] tgt_g,
    input  logic [COLOR_W-1:0] tgt_b,
    output logic [DIST_W-1:0]  sq_dist
);

    logic [COLOR_W-1:0] diff_r, diff_g, diff_b;
    logic [SQ_W-1:0]    sq_r, sq_g, sq_b;
    logic [DIST_W-1:0]  dist_next;

    always_comb
    begin
        diff_r    = (pix_r > tgt_r) ? pix_r - tgt_r : tgt_r - pix_r;
        diff_g    = (pix_g > tgt_g) ? pix_g - tgt_g : tgt_g - pix_g;
        diff_b    = (pix_b > tgt_b) ? pix_b - tgt_b : tgt_b - pix_b;
        sq_r      = SQ_W'(diff_r) * SQ_W'(diff_r);
        sq_g      = SQ_W'(diff_g) * SQ_W'(diff_g);
        sq_b      = SQ_W'(diff_b) * SQ_W'(diff_b);
        dist_next = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_dist <= dist_next;
        end
    end

endmodule

FILE: rtl/core/wncc_xcmp.sv
// Cross-multiplied ratio compare: registered products, then d*wb < db*w.
module wncc_xcmp
    import wncc_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic [DIST_W-1:0]   sq_dist,
    input  logic [WEIGHT_W-1:0] weight,
    input  logic [DIST_W-1:0]   best_dist,
    input  logic [WEIGHT_W-1:0] best_weight,
    output logic                less
);

    logic [PROD_W-1:0] prod_a_reg, prod_b_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_a_reg <= PROD_W'(sq_dist) * PROD_W'(best_weight);
            prod_b_reg <= PROD_W'(best_dist) * PROD_W'(weight);
        end
    end

    assign less = prod_a_reg < prod_b_reg;

endmodule

FILE: rtl/core/weighted_nearest_color_classify.sv
// Weighted nearest-color classifier: seed table, scan sequencer and result register.
//
// Usage:
//   Command beat: start is taken when busy is low. opcode OP_LOAD writes the
//   seed at seed_index (red/green/blue target, paint color, channel, weight)
//   in the same edge and gives no result; busy stays low. An index beyond the
//   table is dropped, a channel above CHANNELS is stored as empty.
//   opcode OP_CLASSIFY takes a pixel and raises busy while the seeds
//   0 .. min(seed_count, MAX_SEEDS)-1 are scanned.
//   Each seed passes in turn through table read, distance, cross products and
//   compare; the next seed is read only after that compare.
//   A classify beat ends in the final state, which registers the result and
//   done (straight from idle when no seed is scanned); done is high for one cycle with the result.
//   A new command can be taken in the cycle done is high.
//   Results cannot be held off by the receiver.
//   cfg_we writes seed_count; write it only while busy is low.
//   Reset clears seed_count and the sequencer; the seed table is not
//   cleared and must be loaded before it is used.
module weighted_nearest_color_classify
    import wncc_pkg::*;
#(
    parameter int MAX_SEEDS = DEF_MAX_SEEDS,
    parameter int CHANNELS  = DEF_CHANNELS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                opcode,
    input  logic [IDX_W-1:0]    seed_index,
    input  logic [COLOR_W-1:0]  red,
    input  logic [COLOR_W-1:0]  green,
    input  logic [COLOR_W-1:0]  blue,
    input  logic [COLOR_W-1:0]  paint_red,
    input  logic [COLOR_W-1:0]  paint_green,
    input  logic [COLOR_W-1:0]  paint_blue,
    input  logic [CH_W-1:0]     channel,
    input  logic [WEIGHT_W-1:0] weight,
    input  logic                cfg_we,
    input  logic [CNT_W-1:0]    cfg_wdata,
    output logic                done,
    output logic [COLOR_W-1:0]  out_red,
    output logic [COLOR_W-1:0]  out_green,
    output logic [COLOR_W-1:0]  out_blue,
    output logic                out_opaque,
    output logic [CH_W-1:0]     out_channel,
    output logic                matched
);

    localparam int AW = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;

    typedef enum logic [5:0]
    {
        ST_IDLE  = 6'b000001,
        ST_READ  = 6'b000010,
        ST_DIST  = 6'b000100,
        ST_MULT  = 6'b001000,
        ST_CMP   = 6'b010000,
        ST_FINAL = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] seed_count_reg, seed_count_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] scan_n_reg, scan_n_next;
    logic [CNT_W-1:0] limit;
    logic             found_reg, found_next;
    logic             done_reg, done_next;

    logic [COLOR_W-1:0]  pix_r_reg, pix_g_reg, pix_b_reg;
    logic [DIST_W-1:0]   best_d_reg;
    logic [WEIGHT_W-1:0] best_w_reg;
    seed_t               best_seed_reg;

    logic [COLOR_W-1:0] out_red_reg, out_green_reg, out_blue_reg;
    logic               out_opaque_reg, matched_reg;
    logic [CH_W-1:0]    out_channel_reg;

    logic          accept;
    logic          wr_en;
    seed_t         wr_seed;
    logic [$bits(seed_t)-1:0] rd_data;
    seed_t         rd_seed;
    logic [DIST_W-1:0] seed_dist;
    logic          less;
    logic          take;
    logic          last;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // table write on a load beat
    always_comb
    begin
        wr_en           = accept && (opcode == OP_LOAD) && (32'(seed_index) < MAX_SEEDS);
        wr_seed.tgt_r   = red;
        wr_seed.tgt_g   = green;
        wr_seed.tgt_b   = blue;
        wr_seed.ch      = (32'(channel) > CHANNELS) ? '0 : channel;
        wr_seed.weight  = weight;
        wr_seed.paint_r = paint_red;
        wr_seed.paint_g = paint_green;
        wr_seed.paint_b = paint_blue;
    end

    wncc_ram
    #(
        .WIDTH ($bits(seed_t)),
        .DEPTH (MAX_SEEDS)
    )
    u_seed_ram
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (AW'(seed_index)),
        .wr_data (wr_seed),
        .rd_en   (state_reg == ST_READ),
        .rd_addr (AW'(cnt_reg)),
        .rd_data (rd_data)
    );

    assign rd_seed = seed_t'(rd_data);

    wncc_dist u_dist
    (
        .clk     (clk),
        .en      (state_reg == ST_DIST),
        .pix_r   (pix_r_reg),
        .pix_g   (pix_g_reg),
        .pix_b   (pix_b_reg),
        .tgt_r   (rd_seed.tgt_r),
        .tgt_g   (rd_seed.tgt_g),
        .tgt_b   (rd_seed.tgt_b),
        .sq_dist (seed_dist)
    );

    wncc_xcmp u_xcmp
    (
        .clk         (clk),
        .en          (state_reg == ST_MULT),
        .sq_dist     (seed_dist),
        .weight      (rd_seed.weight),
        .best_dist   (best_d_reg),
        .best_weight (best_w_reg),
        .less        (less)
    );

    assign limit = (32'(seed_count_reg) > MAX_SEEDS) ? CNT_W'(MAX_SEEDS) : seed_count_reg;
    assign take  = (rd_seed.weight != '0) && (!found_reg || less);
    assign last  = (cnt_reg + CNT_W'(1)) == scan_n_reg;

    always_comb
    begin
        state_next      = state_reg;
        seed_count_next = cfg_we ? cfg_wdata : seed_count_reg;
        cnt_next        = cnt_reg;
        scan_n_next     = scan_n_reg;
        found_next      = found_reg;
        done_next       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (opcode == OP_CLASSIFY))
                begin
                    cnt_next    = '0;
                    scan_n_next = limit;
                    found_next  = 1'b0;
                    state_next  = (limit == '0) ? ST_FINAL : ST_READ;
                end
            end
            ST_READ:  state_next = ST_DIST;
            ST_DIST:  state_next = ST_MULT;
            ST_MULT:  state_next = ST_CMP;
            ST_CMP:
            begin
                if (take)
                begin
                    found_next = 1'b1;
                end
                if (last)
                begin
                    state_next = ST_FINAL;
                end
                else
                begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_FINAL:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            seed_count_reg <= '0;
            cnt_reg        <= '0;
            scan_n_reg     <= '0;
            found_reg      <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            seed_count_reg <= seed_count_next;
            cnt_reg        <= cnt_next;
            scan_n_reg     <= scan_n_next;
            found_reg      <= found_next;
            done_reg       <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept && (opcode == OP_CLASSIFY))
        begin
            pix_r_reg <= red;
            pix_g_reg <= green;
            pix_b_reg <= blue;
        end
        if ((state_reg == ST_CMP) && take)
        begin
            best_d_reg    <= seed_dist;
            best_w_reg    <= rd_seed.weight;
            best_seed_reg <= rd_seed;
        end
        if (state_reg == ST_FINAL)
        begin
            // empty channel or no match gives transparent black
            matched_reg <= found_reg;
            if (found_reg && (best_seed_reg.ch != '0))
            begin
                out_red_reg     <= best_seed_reg.paint_r;
                out_green_reg   <= best_seed_reg.paint_g;
                out_blue_reg    <= best_seed_reg.paint_b;
                out_opaque_reg  <= 1'b1;
                out_channel_reg <= best_seed_reg.ch;
            end
            else
            begin
                out_red_reg     <= '0;
                out_green_reg   <= '0;
                out_blue_reg    <= '0;
                out_opaque_reg  <= 1'b0;
                out_channel_reg <= '0;
            end
        end
    end

    assign done        = done_reg;
    assign out_red     = out_red_reg;
    assign out_green   = out_green_reg;
    assign out_blue    = out_blue_reg;
    assign out_opaque  = out_opaque_reg;
    assign out_channel = out_channel_reg;
    assign matched     = matched_reg;

    a_done_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_FINAL))
        else $error("result beat without final state");

    a_classify_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (opcode == OP_CLASSIFY)) |=> busy)
        else $error("classify beat did not raise busy");

    a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (opcode == OP_LOAD)) |=> !busy)
        else $error("load beat raised busy");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ || state_reg == ST_DIST || state_reg == ST_MULT
         || state_reg == ST_CMP) |-> (cnt_reg < scan_n_reg))
        else $error("scan index beyond seed count");

    a_opaque_match: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && out_opaque_reg) |-> (matched_reg && (out_channel_reg != '0)))
        else $error("opaque result without a matched channel");

endmodule
